/* rtl/damped_spring_integrator_macros.svh */
// Assertion macros for the damped spring integrator.
// Taken in by the top level; needs clk and rst in the including scope.
`ifndef DAMPED_SPRING_INTEGRATOR_MACROS_SVH
`define DAMPED_SPRING_INTEGRATOR_MACROS_SVH
`ifndef SYNTH
`define DSI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DSI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DSI_ASSERT(lbl, prop, msg)
`define DSI_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* rtl/dsi_pkg.sv */
// Shared types, widths and helpers for the damped spring integrator.
// No dependencies; used by every module of the block.
package dsi_pkg;

  localparam int QF       = 16;            // fraction bits of Q values
  localparam int VAL_W    = 32;            // Q value width
  localparam int CFG_W    = 31;            // unsigned coefficient width
  localparam int DT_W     = 17;            // time step width
  localparam int DIFF_W   = VAL_W + 1;     // displacement width
  localparam int PROD_W   = 2 * VAL_W;     // magnitude product width
  localparam int RES_W    = 35;            // clamped signed product result
  localparam int WIDE_W   = 36;            // sums before saturation
  localparam int SUM_W    = PROD_W + 2;    // sum of three squares
  localparam int ROOT_W   = SUM_W / 2;     // length width
  localparam int NUM_W    = VAL_W + QF;    // direction dividend width
  localparam int QUO_W    = QF + 1;        // direction magnitude width
  localparam int IDX_W    = 3;             // register index width

  localparam logic [IDX_W-1:0] REG_REST    = 3'd0;
  localparam logic [IDX_W-1:0] REG_STIFF   = 3'd1;
  localparam logic [IDX_W-1:0] REG_DAMP    = 3'd2;
  localparam logic [IDX_W-1:0] REG_INVM    = 3'd3;
  localparam logic [IDX_W-1:0] REG_START_X = 3'd4;
  localparam logic [IDX_W-1:0] REG_START_Y = 3'd5;
  localparam logic [IDX_W-1:0] REG_START_Z = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_SQRT, S_FMAG, S_DIV, S_SPRING,
    S_DAMP, S_ACC, S_VEL, S_POS, S_DONE
  } state_t;

  // multiplier launch: sgn = sign of the exact product, ng = negate the floored result
  typedef struct packed {
    logic start;
    logic sgn;
    logic ng;
  } mul_req_t;

  function automatic logic [VAL_W-1:0] mag32(input logic signed [DIFF_W-1:0] v);
    logic [DIFF_W-1:0] a;
    a = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
    return a[VAL_W-1:0];
  endfunction

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-VAL_W:0] top;
    top = v[WIDE_W-1:VAL_W-1];
    if (top == '0 || top == '1) return v[VAL_W-1:0];
    else if (v[WIDE_W-1]) return {1'b1, {(VAL_W-1){1'b0}}};
    else return {1'b0, {(VAL_W-1){1'b1}}};
  endfunction

  function automatic logic signed [WIDE_W-1:0] ext32(input logic signed [VAL_W-1:0] v);
    return {{(WIDE_W-VAL_W){v[VAL_W-1]}}, v};
  endfunction

  function automatic logic signed [WIDE_W-1:0] extres(input logic signed [RES_W-1:0] v);
    return {{(WIDE_W-RES_W){v[RES_W-1]}}, v};
  endfunction

endpackage

/* rtl/dsi_mul.sv */
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Gives the raw magnitude product and the floored Q result; uses dsi_pkg.
module dsi_mul import dsi_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  mul_req_t                 req,
  input  logic [VAL_W-1:0]         a,
  input  logic [VAL_W-1:0]         b,
  output logic                     done,
  output logic [PROD_W-1:0]        prod,
  output logic signed [RES_W-1:0]  res
);
  localparam int CNT_W = $clog2(VAL_W);
  localparam int T_W   = PROD_W - QF;
  localparam logic [T_W-1:0] LIM = T_W'(1) << (RES_W - 1);

  logic [VAL_W-1:0] areg;
  logic             sgn, ng, busy;
  logic [CNT_W-1:0] cnt;
  logic [VAL_W:0]   part;
  logic [T_W-1:0]   t;
  logic             neg;

  assign part = {1'b0, prod[PROD_W-1:VAL_W]} + (prod[0] ? {1'b0, areg} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(VAL_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      areg <= a;
      sgn  <= req.sgn;
      ng   <= req.ng;
      prod <= {{VAL_W{1'b0}}, b};
    end else if (busy) begin
      prod <= {part, prod[VAL_W-1:1]};
    end
  end

  // negative products round toward minus infinity: magnitude is the ceiling
  always_comb begin
    t   = prod[PROD_W-1:QF] + (sgn ? T_W'(|prod[QF-1:0]) : '0);
    neg = sgn ^ ng;
    if (neg) res = (t > LIM) ? RES_W'(-LIM) : RES_W'(-t);
    else     res = (t > LIM - 1'b1) ? RES_W'(LIM - 1'b1) : RES_W'(t);
  end
endmodule

/* rtl/dsi_sqrt.sv */
// Digit-serial integer square root, two operand bits per cycle.
// Uses dsi_pkg widths.
module dsi_sqrt import dsi_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SUM_W-1:0]  opnd,
  output logic              done,
  output logic [ROOT_W-1:0] root
);
  localparam int CNT_W = $clog2(ROOT_W);
  localparam int R_W   = ROOT_W + 4;

  logic [SUM_W-1:0] sh;
  logic [R_W-1:0]   r, r2, trial;
  logic             busy;
  logic [CNT_W-1:0] cnt;

  assign r2    = {r[R_W-3:0], sh[SUM_W-1:SUM_W-2]};
  assign trial = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh   <= opnd;
      r    <= '0;
      root <= '0;
    end else if (busy) begin
      sh <= {sh[SUM_W-3:0], 2'b00};
      if (r2 >= trial) begin
        r    <= r2 - trial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        r    <= r2;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end
endmodule

/* rtl/dsi_div.sv */
// Restoring divider, one quotient bit per cycle, for the unit direction.
// Dividend is the magnitude scaled by the fraction; uses dsi_pkg.
module dsi_div import dsi_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [VAL_W-1:0]  num,
  input  logic [ROOT_W-1:0] den,
  output logic              done,
  output logic [QUO_W-1:0]  quo
);
  localparam int CNT_W = $clog2(NUM_W);
  localparam int REM_W = ROOT_W + 1;

  logic [NUM_W-1:0]  sh;
  logic [REM_W-1:0]  rem, rem2;
  logic [ROOT_W-1:0] dreg;
  logic              busy;
  logic [CNT_W-1:0]  cnt;

  assign rem2 = {rem[REM_W-2:0], sh[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient never exceeds one in Q form, so only the low bits are kept
  always_ff @(posedge clk) begin
    if (start) begin
      sh   <= {num, {QF{1'b0}}};
      rem  <= '0;
      dreg <= den;
      quo  <= '0;
    end else if (busy) begin
      sh <= {sh[NUM_W-2:0], 1'b0};
      if (rem2 >= {1'b0, dreg}) begin
        rem <= rem2 - {1'b0, dreg};
        quo <= {quo[QUO_W-2:0], 1'b1};
      end else begin
        rem <= rem2;
        quo <= {quo[QUO_W-2:0], 1'b0};
      end
    end
  end
endmodule

/* rtl/damped_spring_integrator.sv */
// Damped spring end integrator, semi-implicit Euler, signed Q16.16, saturating.
// One word in flight: a new input word is taken only in the idle state, once the
// last result has been loaded into the output register. Work is paced by the
// shared bit-serial multiplier (five products per axis, four when the length is
// zero), the direction divider and the square root. Synchronous active-high rst
// clears position, velocity and registers (inverse mass to 1.0).
module damped_spring_integrator import dsi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // input words
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [119:0]         s_axis_tdata,  // target_x, target_y, target_z, time_step, pad
  // result words
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [191:0]         m_axis_tdata,  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
  // register writes
  input  logic                 cfg_we,
  input  logic [IDX_W-1:0]     cfg_index,
  input  logic [VAL_W-1:0]     cfg_data
);
`include "damped_spring_integrator_macros.svh"

  state_t state, state_next;
  logic   kick;
  logic [1:0] ax;

  // coefficients
  logic [CFG_W-1:0] rest, stiff, dampc, invm;

  // dynamic state and per-word scratch
  logic signed [VAL_W-1:0]  pos [3];
  logic signed [VAL_W-1:0]  vel [3];
  logic signed [DIFF_W-1:0] d   [3];
  logic [DT_W-1:0]          dt;
  logic [SUM_W-1:0]         sum;
  logic [ROOT_W-1:0]        len;
  logic signed [VAL_W-1:0]  fmag, spring, dmp, acc;

  logic accept;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE) && !rst;

  // unit handshakes
  mul_req_t             mreq;
  logic [VAL_W-1:0]     ma, mb;
  logic                 mdone, sdone, ddone, sstart, dstart;
  logic [PROD_W-1:0]    mprod;
  logic signed [RES_W-1:0] mres;
  logic [ROOT_W-1:0]    root;
  logic [QUO_W-1:0]     quo;

  logic signed [VAL_W-1:0] lr, force_v;
  assign lr      = sat32(WIDE_W'({3'b000, len}) - WIDE_W'({5'b00000, rest}));
  assign force_v = sat32(ext32(spring) + ext32(dmp));

  dsi_mul u_mul (
    .clk(clk), .rst(rst), .req(mreq), .a(ma), .b(mb),
    .done(mdone), .prod(mprod), .res(mres)
  );

  dsi_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sstart), .opnd(sum), .done(sdone), .root(root)
  );

  dsi_div u_div (
    .clk(clk), .rst(rst), .start(dstart), .num(mag32(d[ax])), .den(len),
    .done(ddone), .quo(quo)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept) state_next = S_SQ;
      S_SQ:     if (mdone && ax == 2'd2) state_next = S_SQRT;
      S_SQRT:   if (sdone) state_next = S_FMAG;
      S_FMAG:   if (mdone) state_next = (len == '0) ? S_DAMP : S_DIV;
      S_DIV:    if (ddone) state_next = S_SPRING;
      S_SPRING: if (mdone) state_next = S_DAMP;
      S_DAMP:   if (mdone) state_next = S_ACC;
      S_ACC:    if (mdone) state_next = S_VEL;
      S_VEL:    if (mdone) state_next = S_POS;
      S_POS: begin
        if (mdone) begin
          if (ax == 2'd2) state_next = S_DONE;
          else state_next = (len == '0) ? S_DAMP : S_DIV;
        end
      end
      S_DONE:   if (!m_axis_tvalid || m_axis_tready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // unit launches and operand selection
  always_comb begin
    mreq   = '0;
    ma     = '0;
    mb     = '0;
    sstart = 1'b0;
    dstart = 1'b0;
    case (state)
      S_SQ: begin
        mreq.start = kick;
        ma = mag32(d[ax]);
        mb = mag32(d[ax]);
      end
      S_SQRT: sstart = kick;
      S_FMAG: begin
        mreq.start = kick;
        mreq.sgn   = lr[VAL_W-1];
        ma = {1'b0, stiff};
        mb = mag32({lr[VAL_W-1], lr});
      end
      S_DIV: dstart = kick;
      S_SPRING: begin
        mreq = '{start: kick, sgn: fmag[VAL_W-1] ^ d[ax][DIFF_W-1], ng: 1'b1};
        ma = mag32({fmag[VAL_W-1], fmag});
        mb = VAL_W'(quo);
      end
      S_DAMP: begin
        mreq = '{start: kick, sgn: vel[ax][VAL_W-1], ng: 1'b1};
        ma = {1'b0, dampc};
        mb = mag32({vel[ax][VAL_W-1], vel[ax]});
      end
      S_ACC: begin
        mreq.start = kick;
        mreq.sgn   = force_v[VAL_W-1];
        ma = mag32({force_v[VAL_W-1], force_v});
        mb = {1'b0, invm};
      end
      S_VEL: begin
        mreq.start = kick;
        mreq.sgn   = acc[VAL_W-1];
        ma = mag32({acc[VAL_W-1], acc});
        mb = VAL_W'(dt);
      end
      S_POS: begin
        mreq.start = kick;
        mreq.sgn   = vel[ax][VAL_W-1];
        ma = mag32({vel[ax][VAL_W-1], vel[ax]});
        mb = VAL_W'(dt);
      end
      default: ;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      kick          <= 1'b0;
      ax            <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      // new unit run on each state entry, and per axis while summing squares
      kick  <= (state_next != state) || (state == S_SQ && mdone);
      if (state == S_DONE && (!m_axis_tvalid || m_axis_tready)) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        S_IDLE:  ax <= '0;
        S_SQ:    if (mdone) ax <= (ax == 2'd2) ? 2'd0 : ax + 1'b1;
        S_POS:   if (mdone && ax != 2'd2) ax <= ax + 1'b1;
        default: ;
      endcase
    end
  end

  // coefficients and dynamic state
  always_ff @(posedge clk) begin
    if (rst) begin
      rest  <= '0;
      stiff <= '0;
      dampc <= '0;
      invm  <= CFG_W'(1) << QF;
      for (int i = 0; i < 3; i++) begin
        pos[i] <= '0;
        vel[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_REST:  rest  <= cfg_data[CFG_W-1:0];
          REG_STIFF: stiff <= cfg_data[CFG_W-1:0];
          REG_DAMP:  dampc <= cfg_data[CFG_W-1:0];
          REG_INVM:  invm  <= cfg_data[CFG_W-1:0];
          REG_START_X, REG_START_Y, REG_START_Z: begin
            pos[2'(cfg_index - REG_START_X)] <= cfg_data;
            for (int i = 0; i < 3; i++) vel[i] <= '0;
          end
          default: ;
        endcase
      end
      if (state == S_VEL && mdone) vel[ax] <= sat32(ext32(vel[ax]) + extres(mres));
      if (state == S_POS && mdone) pos[ax] <= sat32(ext32(pos[ax]) + extres(mres));
    end
  end

  // scratch, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 3; i++)
        d[i] <= {pos[i][VAL_W-1], pos[i]} -
                {s_axis_tdata[32*i+31], s_axis_tdata[32*i +: VAL_W]};
      dt  <= s_axis_tdata[96 +: DT_W];
      sum <= '0;
    end
    if (state == S_SQ && mdone) sum <= sum + SUM_W'(mprod);
    if (sdone) len <= root;
    if (state == S_FMAG && mdone) begin
      fmag   <= sat32(extres(mres));
      spring <= '0;   // zero length: no spring force on any axis
    end
    if (state == S_SPRING && mdone) spring <= sat32(extres(mres));
    if (state == S_DAMP && mdone)   dmp    <= sat32(extres(mres));
    if (state == S_ACC && mdone)    acc    <= sat32(extres(mres));
    if (state == S_DONE && (!m_axis_tvalid || m_axis_tready))
      m_axis_tdata <= {vel[2], vel[1], vel[0], pos[2], pos[1], pos[0]};
  end

  // one arithmetic unit finishes at a time
  `DSI_ASSERT(a_one_unit_done, $onehot0({mdone, sdone, ddone}), "two units finished together")
  // a word taken starts work at once, no second word behind it
  `DSI_ASSERT(a_single_word, accept |=> !s_axis_tready, "input taken twice in a row")
  // results only come out of the final step
  `DSI_ASSERT(a_out_from_done, $rose(m_axis_tvalid) |-> $past(state == S_DONE), "result without work")

endmodule

/* sim/dsi_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the damped spring integrator: predicts each result word from
// the accepted input words and register writes, then compares. Needs dsi_pkg.
module dsi_checker import dsi_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  input  logic [119:0]     s_axis_tdata,  // target_x, target_y, target_z, time_step, pad
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic [191:0]     m_axis_tdata,  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0] cfg_data,
  output int               errors,
  output int               outstanding,
  output int               results_seen
);

  // Last member sits in the low bits, so pos_x lands at [31:0].
  typedef struct packed {
    logic signed [31:0] vel_z, vel_y, vel_x, pos_z, pos_y, pos_x;
  } spring_word_t;

  spring_word_t expected_q[$];
  longint       end_pos[3];
  longint       end_vel[3];
  longint       rest_len, stiff, damp_k, inv_mass;

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // exact product, floored back to Q16.16
  function automatic longint qmul(input longint a, input longint b);
    longint p;
    p = a * b;
    return p >>> QF;
  endfunction

  function automatic longint root_floor(input logic [67:0] v);
    logic [71:0] rem, q, trial;
    rem = '0;
    q = '0;
    for (int i = 33; i >= 0; i--) begin
      rem = (rem << 2) | 72'(v[2*i +: 2]);
      trial = (q << 2) | 72'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        q = (q << 1) | 72'd1;
      end else begin
        q = q << 1;
      end
    end
    return longint'(q[35:0]);
  endfunction

  function automatic spring_word_t step_spring(input logic [119:0] w);
    longint      disp[3], mag[3];
    logic [67:0] sq_sum;
    longint      len, fmag, dt, spring, dmp, force_sum, acc, dir;
    spring_word_t r;
    sq_sum = '0;
    fmag = 0;
    dt = longint'(w[112:96]);
    for (int i = 0; i < 3; i++) begin
      disp[i] = end_pos[i] - longint'($signed(w[32*i +: 32]));
      mag[i] = disp[i] < 0 ? -disp[i] : disp[i];
      sq_sum = sq_sum + 68'(mag[i]) * 68'(mag[i]);
    end
    len = root_floor(sq_sum);
    if (len != 0) fmag = clamp32(qmul(stiff, clamp32(len - rest_len)));
    for (int i = 0; i < 3; i++) begin
      spring = 0;
      if (len != 0) begin
        dir = (mag[i] << QF) / len;
        if (disp[i] < 0) dir = -dir;
        spring = clamp32(-qmul(fmag, dir));
      end
      dmp = clamp32(-qmul(damp_k, end_vel[i]));
      force_sum = clamp32(spring + dmp);
      acc = clamp32(qmul(force_sum, inv_mass));
      end_vel[i] = clamp32(end_vel[i] + qmul(acc, dt));
      end_pos[i] = clamp32(end_pos[i] + qmul(end_vel[i], dt));
    end
    r.pos_x = end_pos[0][31:0];
    r.pos_y = end_pos[1][31:0];
    r.pos_z = end_pos[2][31:0];
    r.vel_x = end_vel[0][31:0];
    r.vel_y = end_vel[1][31:0];
    r.vel_z = end_vel[2][31:0];
    return r;
  endfunction

  task automatic cmp_field(input string name, input logic [31:0] exp_v, input logic [31:0] got);
    if (exp_v !== got) begin
      $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(got));
      errors++;
    end
  endtask

  always @(posedge clk) begin
    spring_word_t exp_w, got_w;
    if (rst) begin
      expected_q.delete();
      for (int i = 0; i < 3; i++) begin
        end_pos[i] = 0;
        end_vel[i] = 0;
      end
      rest_len = 0;
      stiff = 0;
      damp_k = 0;
      inv_mass = 65536;
      errors = 0;
      results_seen = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_REST:  rest_len = longint'(cfg_data[30:0]);
          REG_STIFF: stiff = longint'(cfg_data[30:0]);
          REG_DAMP:  damp_k = longint'(cfg_data[30:0]);
          REG_INVM:  inv_mass = longint'(cfg_data[30:0]);
          REG_START_X, REG_START_Y, REG_START_Z: begin
            // start load also kills all velocity
            end_pos[cfg_index - REG_START_X] = longint'($signed(cfg_data));
            for (int i = 0; i < 3; i++) end_vel[i] = 0;
          end
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) expected_q.push_back(step_spring(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        got_w = m_axis_tdata;
        if (expected_q.size() == 0) begin
          $error("result word with nothing expected: %h", m_axis_tdata);
          errors++;
        end else begin
          exp_w = expected_q.pop_front();
          cmp_field("pos_x", exp_w.pos_x, got_w.pos_x);
          cmp_field("pos_y", exp_w.pos_y, got_w.pos_y);
          cmp_field("pos_z", exp_w.pos_z, got_w.pos_z);
          cmp_field("vel_x", exp_w.vel_x, got_w.vel_x);
          cmp_field("vel_y", exp_w.vel_y, got_w.vel_y);
          cmp_field("vel_z", exp_w.vel_z, got_w.vel_z);
        end
      end
    end
    outstanding = expected_q.size();
  end

endmodule

/* sim/tb_damped_spring_integrator.sv */
`timescale 1ns / 100ps
// Top of the damped spring integrator testbench: clock, reset, stimulus and verdict.
// Depends on dsi_pkg, damped_spring_integrator and dsi_checker.
module tb_damped_spring_integrator;
  import dsi_pkg::*;

  localparam int CYCLE_LIMIT = 4_000_000;  // every word's work plus stalls, several times over
  localparam int DRAIN_CYCLES = 1000;       // a bit more than one word's latency

  logic             clk;
  logic             rst;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [119:0]     s_axis_tdata;   // target_x, target_y, target_z, time_step, pad
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [191:0]     m_axis_tdata;   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [VAL_W-1:0] cfg_data;

  int errors, outstanding, results_seen;
  int cycles;
  int words_sent;
  int burst_left;

  damped_spring_integrator i_dut (.*);

  dsi_checker i_checker (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: changes its stall style every so often; one long hold-off early on
  // while the sender keeps offering, so the input side backs up.
  initial begin
    int style, style_left, hold_left;
    style = 0;
    style_left = 0;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (cycles == 20000) hold_left = 6000;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (style_left == 0) begin
          style = $urandom_range(0, 2);
          style_left = $urandom_range(50, 3000);
        end
        style_left--;
        case (style)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 1) == 1);
          default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Present one word starting at this falling edge; valid stays up within a burst.
  task automatic send_word(input logic signed [31:0] tx, input logic signed [31:0] ty,
                           input logic signed [31:0] tz, input logic [16:0] dt);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, dt, tz, ty, tx};
    do @(posedge clk); while (!s_axis_tready);
    words_sent++;
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(negedge clk);
      burst_left = $urandom_range(1, 10);
    end
  endtask

  // Drop valid and wait until every word has come back, so registers may change.
  task automatic settle;
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // Coefficient pick: extremes, full 32-bit noise (bit 31 is dropped), or moderate.
  function automatic logic [31:0] pick_coef();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      default: return $urandom_range(0, 32'h0020_0000);
    endcase
  endfunction

  function automatic logic [31:0] pick_coord();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
    return $urandom;
  endfunction

  function automatic logic [16:0] pick_dt();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 17'($urandom_range(0, 4096));
    if (r < 9) return 17'($urandom_range(0, 65536));
    return 17'($urandom_range(0, 131071));   // up to just under two seconds, used as given
  endfunction

  initial begin
    logic signed [31:0] max_v, min_v;
    max_v = 32'sh7fff_ffff;
    min_v = 32'sh8000_0000;
    cycles = 0;
    words_sent = 0;
    burst_left = 3;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: zero stiffness, target at the spring end means zero length.
    send_word(0, 0, 0, 17'd65536);
    send_word(max_v, min_v, max_v, 17'd0);
    send_word(min_v, max_v, min_v, 17'd131071);
    settle();

    // A well-behaved spring, then a near-zero length and odd time steps.
    write_reg(REG_REST, 32'h0001_0000);
    write_reg(REG_STIFF, 32'h000a_0000);
    write_reg(REG_DAMP, 32'h0000_8000);
    write_reg(REG_INVM, 32'h0001_0000);
    write_reg(REG_START_X, 32'h0002_0000);
    write_reg(REG_START_Y, 32'hfffe_0000);
    write_reg(REG_START_Z, 32'h0000_0000);
    write_reg(3'd7, 32'hdead_beef);        // unused index, must change nothing
    for (int i = 0; i < 6; i++) send_word(0, 0, 0, 17'h0_1000);
    send_word(0, 0, 0, 17'd1);
    send_word(0, 0, 0, 17'd65536);
    settle();

    // Everything at the top of its range: saturation everywhere.
    write_reg(REG_REST, 32'hffff_ffff);
    write_reg(REG_STIFF, 32'h7fff_ffff);
    write_reg(REG_DAMP, 32'h7fff_ffff);
    write_reg(REG_INVM, 32'h7fff_ffff);
    write_reg(REG_START_X, max_v);
    write_reg(REG_START_Y, min_v);
    write_reg(REG_START_Z, max_v);
    send_word(min_v, max_v, min_v, 17'd131071);
    send_word(max_v, min_v, max_v, 17'd65536);
    send_word(max_v, max_v, max_v, 17'd131071);
    settle();
    write_reg(REG_REST, 32'd0);
    write_reg(REG_START_X, 32'd0);
    write_reg(REG_START_Y, 32'd0);
    write_reg(REG_START_Z, 32'd0);
    send_word(0, 0, 0, 17'd65536);         // zero length with damping and velocity zero
    send_word(32'sd5, -32'sd5, 32'sd1, 17'd65536);
    settle();

    // Random phases: new registers each time, targets mostly near the origin.
    for (int phase = 0; phase < 8; phase++) begin
      write_reg(REG_REST, pick_coef());
      write_reg(REG_STIFF, pick_coef());
      write_reg(REG_DAMP, pick_coef());
      write_reg(REG_INVM, pick_coef());
      write_reg(REG_START_X, pick_coord());
      write_reg(REG_START_Y, pick_coord());
      write_reg(REG_START_Z, pick_coord());
      write_reg(3'd7, $urandom);
      for (int n = 0; n < 75; n++) send_word(pick_coord(), pick_coord(), pick_coord(), pick_dt());
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d target words and %0d result words over %0d cycles,",
             words_sent, results_seen, cycles);
    $display("with register extremes, zero-length springs and long receiver hold-offs.");
    if (errors == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/dsi_pkg.sv
rtl/dsi_mul.sv
rtl/dsi_sqrt.sv
rtl/dsi_div.sv
rtl/damped_spring_integrator.sv
sim/dsi_checker.sv
sim/tb_damped_spring_integrator.sv
